// ----- hdl/fdlc_pkg.sv -----
// Shared constants and types for the fractional delay line with cubic interpolation.
// No dependencies; imported by fdlc_cubic, fractional_delay_line_cubic_top and the testbench.
package fdlc_pkg;

	localparam int DEF_BUF_LEN     = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	// delay is held in 1/256 sample units
	localparam int FRAC_BITS   = 8;
	localparam int FRAC_ONE    = 256;
	localparam int DELAY_W     = 18;
	localparam int DELAY_MIN   = 26;
	localparam int DELAY_RESET = 131072;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY  = 1'b0,
		REG_INTERP = 1'b1
	} cfg_reg_t;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = 2;
	localparam int RES_CW    = 3;

	// which neighbor a memory read fetches
	typedef enum logic [1:0] {
		PH_M1,
		PH_0,
		PH_P1,
		PH_P2
	} tap_phase_t;

	// handoff from the tap gather logic into the interpolator
	typedef struct packed {
		logic                 vld;
		logic                 interp_on;
		logic [FRAC_BITS-1:0] frac;
	} fdlc_ctl_t;

endpackage

// ----- hdl/fractional_delay_line_cubic_top.sv -----
// Fractional delay line, top level: sample memory, tap sequencer, result queue.
// Depends on fdlc_pkg and fdlc_cubic.
//
// Each input beat writes one Q1.15 sample into a BUF_LEN-entry circular memory
// and returns one output beat: the sample delay_amount/256 samples back, either
// the plain integer tap or a cubic blend of four neighbors (rounded, saturated).
// The four neighbor taps are fetched one per cycle through the memory's single
// read port, also with interpolation off; a new beat can start as the last read
// of the previous one issues. Results pass the tap gather registers, the cubic
// interpolator and the queue before output valid rises. Up to four beats may be in
// flight; a four-entry result queue absorbs output backpressure, and the input
// keeps taking beats while results wait. The memory needs no clearing pass
// after reset: a fill count marks entries not yet written, which read as zero.
// Delay writes below 26 are raised to 26; delays of BUF_LEN*256 or more act as
// (BUF_LEN-1)*256. Configuration writes are meant for idle periods only.
module fractional_delay_line_cubic_top #(
	parameter int BUF_LEN     = fdlc_pkg::DEF_BUF_LEN,
	parameter int SAMPLE_BITS = fdlc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     sample_out,
	input  logic                              cfg_we,
	input  logic [fdlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdlc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fdlc_pkg::*;

	localparam int AW       = $clog2(BUF_LEN);
	localparam int FW       = $clog2(BUF_LEN + 1);
	localparam int HALF_LEN = BUF_LEN / 2;
	localparam int TOTAL    = BUF_LEN * FRAC_ONE;
	localparam int EW       = (DELAY_W > AW + FRAC_BITS + 1) ? DELAY_W : AW + FRAC_BITS + 1;

	// Clamp a delay word into the usable range.
	function automatic logic [EW-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
		logic [EW-1:0] dx;
		dx = EW'(d);
		if (dx < EW'(DELAY_MIN)) begin
			dx = EW'(DELAY_MIN);
		end else if (dx >= EW'(TOTAL)) begin
			dx = EW'(TOTAL - FRAC_ONE);
		end
		return dx;
	endfunction

	// Read tap = write position + offset (mod BUF_LEN). A nonzero fraction
	// pulls the tap one further back and flips the fraction to 256 - g.
	function automatic logic [AW-1:0] delay_offset(input logic [DELAY_W-1:0] d);
		logic [EW-1:0] dx;
		logic [AW:0]   back;
		dx   = clamp_delay(d);
		back = (AW+1)'(dx[EW-1:FRAC_BITS]) + (AW+1)'(dx[FRAC_BITS-1:0] != '0);
		return AW'((AW+1)'(BUF_LEN) - back);
	endfunction

	function automatic logic [FRAC_BITS-1:0] delay_frac(input logic [DELAY_W-1:0] d);
		logic [EW-1:0] dx;
		dx = clamp_delay(d);
		return FRAC_BITS'(0) - dx[FRAC_BITS-1:0];
	endfunction

	// configuration
	logic [AW-1:0]        offset_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 interp_q;

	// write side
	logic [AW-1:0]        wp_q;
	logic [FW-1:0]        fill_q;
	logic [AW:0]          wp_inc;
	logic [AW:0]          rp_sum;
	logic [AW-1:0]        rp_d;

	// issue stage: one memory read per cycle while a beat is active
	logic                 in_acc;
	logic                 act_s1, act_d;
	tap_phase_t           ph_s1, ph_d;
	logic [AW-1:0]        wp_s1, rp_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [AW-1:0]        pm1, pp1, pp2, rd_addr, ent_ofs;
	logic [AW:0]          sum1, sum2;
	logic                 wr_en;

	// read return stage
	logic                 vld_s2, fwd_s2, known_s2;
	tap_phase_t           ph_s2;
	logic signed [SAMPLE_BITS-1:0] smp_s2, rd_s2, tap;

	// gathered taps
	logic signed [SAMPLE_BITS-1:0] ym1_s3, y0_s3, y1_s3;

	// sample memory
	logic signed [SAMPLE_BITS-1:0] mem [BUF_LEN];

	// interpolator handoff
	fdlc_ctl_t            ctl;
	logic                 res_vld;
	logic signed [SAMPLE_BITS-1:0] res;

	// result queue
	logic signed [SAMPLE_BITS-1:0] res_q [RES_DEPTH];
	logic [RES_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [RES_CW-1:0]    cnt_q, credit_q;
	logic                 out_acc;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= delay_offset(DELAY_W'(DELAY_RESET));
			frac_q   <= delay_frac(DELAY_W'(DELAY_RESET));
			interp_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY: begin
					offset_q <= delay_offset(cfg_data[DELAY_W-1:0]);
					frac_q   <= delay_frac(cfg_data[DELAY_W-1:0]);
				end
				REG_INTERP: begin
					interp_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- input side ----------------
	// A new beat may start while the last read of the previous one issues.
	// Credits bound the beats in flight to the result queue depth.
	assign in_ready = (!act_s1 || ph_s1 == PH_P2) && (credit_q != RES_CW'(RES_DEPTH));
	assign in_acc   = in_valid && in_ready;

	assign wp_inc = {1'b0, wp_q} + (AW+1)'(1);
	assign rp_sum = {1'b0, wp_q} + {1'b0, offset_q};
	assign rp_d   = (rp_sum >= (AW+1)'(BUF_LEN)) ? AW'(rp_sum - (AW+1)'(BUF_LEN))
	                                              : AW'(rp_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= AW'(HALF_LEN);
			fill_q <= '0;
		end else if (in_acc) begin
			wp_q <= (wp_inc >= (AW+1)'(BUF_LEN)) ? '0 : AW'(wp_inc);
			if (fill_q != FW'(BUF_LEN)) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// ---------------- tap sequencer ----------------
	always_comb begin
		act_d = act_s1 && (ph_s1 != PH_P2);
		ph_d  = ph_s1;
		if (in_acc) begin
			act_d = 1'b1;
			ph_d  = PH_M1;
		end else begin
			case (ph_s1)
				PH_M1:   ph_d = PH_0;
				PH_0:    ph_d = PH_P1;
				PH_P1:   ph_d = PH_P2;
				default: ph_d = PH_P2;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			ph_s1  <= PH_M1;
		end else begin
			act_s1 <= act_d;
			ph_s1  <= ph_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			wp_s1  <= wp_q;
			rp_s1  <= rp_d;
			smp_s1 <= sample_in;
		end
	end

	// neighbor addresses around the tap
	assign sum1 = {1'b0, rp_s1} + (AW+1)'(1);
	assign sum2 = {1'b0, rp_s1} + (AW+1)'(2);
	assign pm1  = (rp_s1 == '0) ? AW'(BUF_LEN - 1) : rp_s1 - AW'(1);
	assign pp1  = (sum1 >= (AW+1)'(BUF_LEN)) ? AW'(sum1 - (AW+1)'(BUF_LEN)) : AW'(sum1);
	assign pp2  = (sum2 >= (AW+1)'(BUF_LEN)) ? AW'(sum2 - (AW+1)'(BUF_LEN)) : AW'(sum2);

	always_comb begin
		case (ph_s1)
			PH_M1:   rd_addr = pm1;
			PH_0:    rd_addr = rp_s1;
			PH_P1:   rd_addr = pp1;
			PH_P2:   rd_addr = pp2;
			default: rd_addr = rp_s1;
		endcase
	end

	// sample is written in the first slot; the same-cycle read returns old
	// data, so a read of the write entry takes the new sample instead
	assign wr_en = act_s1 && (ph_s1 == PH_M1);

	// position of the read entry, counted from the reset write position
	assign ent_ofs = (rd_addr >= AW'(HALF_LEN)) ? rd_addr - AW'(HALF_LEN)
	                                            : rd_addr + AW'(BUF_LEN - HALF_LEN);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_s1] <= smp_s1;
		end
		if (act_s1) begin
			rd_s2 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		ph_s2    <= ph_s1;
		fwd_s2   <= (rd_addr == wp_s1);
		known_s2 <= (FW'(ent_ofs) < fill_q);
		smp_s2   <= smp_s1;
	end

	// never-written entries read as zero
	assign tap = fwd_s2 ? smp_s2 : (known_s2 ? rd_s2 : '0);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			case (ph_s2)
				PH_M1:   ym1_s3 <= tap;
				PH_0:    y0_s3  <= tap;
				PH_P1:   y1_s3  <= tap;
				default: begin
				end
			endcase
		end
	end

	// ---------------- interpolation ----------------
	assign ctl.vld       = vld_s2 && (ph_s2 == PH_P2);
	assign ctl.interp_on = interp_q;
	assign ctl.frac      = frac_q;

	fdlc_cubic #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_cubic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.ym1     (ym1_s3),
		.y0      (y0_s3),
		.y1      (y1_s3),
		.y2      (tap),
		.res_vld (res_vld),
		.res     (res)
	);

	// ---------------- result queue ----------------
	assign out_valid  = (cnt_q != '0);
	assign out_acc    = out_valid && out_ready;
	assign sample_out = res_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_vld) begin
			res_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			credit_q <= '0;
		end else begin
			if (res_vld) begin
				wr_ptr_q <= wr_ptr_q + RES_AW'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			end
			cnt_q    <= cnt_q + RES_CW'(res_vld) - RES_CW'(out_acc);
			credit_q <= credit_q + RES_CW'(in_acc) - RES_CW'(out_acc);
		end
	end

endmodule

// ----- hdl/fdlc_cubic.sv -----
// Five-stage cubic interpolator: Horner form over four taps, round, saturate; y0 passes through when off.
// Depends on fdlc_pkg (FRAC_BITS, fdlc_ctl_t).
module fdlc_cubic #(
	parameter int SAMPLE_BITS = fdlc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdlc_pkg::fdlc_ctl_t           ctl,
	input  logic signed [SAMPLE_BITS-1:0] ym1,
	input  logic signed [SAMPLE_BITS-1:0] y0,
	input  logic signed [SAMPLE_BITS-1:0] y1,
	input  logic signed [SAMPLE_BITS-1:0] y2,
	output logic                          res_vld,
	output logic signed [SAMPLE_BITS-1:0] res
);
	import fdlc_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int CAW = SB + 2;
	localparam int CBW = SB + 3;
	localparam int CCW = SB + 1;
	localparam int H1W = SB + 12;
	localparam int H2W = SB + 21;
	localparam int H3W = SB + 30;
	localparam int QW  = H3W - 3*FRAC_BITS;

	localparam logic signed [H3W-1:0] HALF = H3W'(1) <<< (3*FRAC_BITS - 1);
	localparam logic signed [QW-1:0]  QMAX = {{(QW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [QW-1:0]  QMIN = {{(QW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	// stage 1: polynomial coefficients
	logic signed [CAW-1:0]       ca_d, ca_s1;
	logic signed [CBW-1:0]       cb_d, cb_s1;
	logic signed [CCW-1:0]       cc_d, cc_s1, cc_s2;
	logic signed [SB-1:0]        y0_s1, y0_s2, y0_s3, y0_s4;
	logic [FRAC_BITS-1:0]        f_s1, f_s2, f_s3;
	logic                        on_s1, on_s2, on_s3, on_s4;
	logic                        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [H1W-1:0]       h1_d, h1_s2;
	logic signed [H2W-1:0]       h2_d, h2_s3;
	logic signed [H3W-1:0]       h3_d, h3_s4;
	logic signed [FRAC_BITS:0]   fs1, fs2, fs3;
	logic signed [QW-1:0]        q;
	logic signed [SB-1:0]        res_d, res_s5;

	assign ca_d = CAW'(y0) - CAW'(y1) + CAW'(y2) - CAW'(ym1);
	assign cb_d = (CBW'(ym1) <<< 1) - (CBW'(y0) <<< 1) + CBW'(y1) - CBW'(y2);
	assign cc_d = CCW'(y1) - CCW'(ym1);

	assign fs1 = $signed({1'b0, f_s1});
	assign fs2 = $signed({1'b0, f_s2});
	assign fs3 = $signed({1'b0, f_s3});

	// Horner: ((f*ca + 256*cb)*f + 65536*cc)*f + 2^24*y0 + 2^23
	assign h1_d = H1W'(ca_s1) * H1W'(fs1) + (H1W'(cb_s1) <<< FRAC_BITS);
	assign h2_d = H2W'(h1_s2) * H2W'(fs2) + (H2W'(cc_s2) <<< (2*FRAC_BITS));
	assign h3_d = H3W'(h2_s3) * H3W'(fs3) + (H3W'(y0_s3) <<< (3*FRAC_BITS)) + HALF;

	// arithmetic shift floors, so the added half rounds ties upward
	assign q = h3_s4[H3W-1:3*FRAC_BITS];

	always_comb begin
		if (!on_s4) begin
			res_d = y0_s4;
		end else if (q > QMAX) begin
			res_d = QMAX[SB-1:0];
		end else if (q < QMIN) begin
			res_d = QMIN[SB-1:0];
		end else begin
			res_d = q[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= ctl.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ca_s1  <= ca_d;
		cb_s1  <= cb_d;
		cc_s1  <= cc_d;
		y0_s1  <= y0;
		f_s1   <= ctl.frac;
		on_s1  <= ctl.interp_on;

		h1_s2  <= h1_d;
		cc_s2  <= cc_s1;
		y0_s2  <= y0_s1;
		f_s2   <= f_s1;
		on_s2  <= on_s1;

		h2_s3  <= h2_d;
		y0_s3  <= y0_s2;
		f_s3   <= f_s2;
		on_s3  <= on_s2;

		h3_s4  <= h3_d;
		y0_s4  <= y0_s3;
		on_s4  <= on_s3;

		res_s5 <= res_d;
	end

	assign res_vld = v_s5;
	assign res     = res_s5;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for fractional_delay_line_cubic_top: plain and cubic taps,
// clamps, saturation, with random idling on the sample input and result output.
// Depends on fdlc_pkg and the RTL top level; needs no files at run time.
module testbench;
	import fdlc_pkg::*;

	localparam int LINE_LEN   = DEF_BUF_LEN;
	localparam int LINE_AW    = $clog2(LINE_LEN);
	localparam int LINE_UNITS = LINE_LEN * FRAC_ONE;   // whole store in 1/256 steps
	localparam int MAX_IDLE   = 18;
	localparam int END_SETTLE = 20;                    // settle time after the line drains
	localparam int N_PHASES   = 12;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_CFG
	} row_kind_t;

	// one directed step: either a register write or a sample beat;
	// pinned marks a row whose result is typed in by hand
	typedef struct packed {
		row_kind_t          kind;
		cfg_reg_t           reg_sel;
		logic [DELAY_W-1:0] cfg_val;
		logic signed [15:0] smp;
		logic               pinned;
		logic signed [15:0] want;
	} stim_row_t;

	localparam int N_ROWS = 25;
	localparam int ROW_AW = $clog2(N_ROWS);
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// after reset: 512-sample delay into an all-zero store
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh8000, 1'b1, 16'sd0},
		// zero delay acts as the 0.1-sample minimum: plain tap is one sample back
		'{ROW_CFG,    REG_DELAY,  18'd0,      16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sd100,  1'b1, 16'sh8000},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sd5,    1'b1, 16'sd100},
		// cubic at the minimum delay: the y1 neighbor is the sample just written
		'{ROW_CFG,    REG_INTERP, 18'd1,      16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh8000, 1'b0, 16'sd0},
		// half-sample fraction over full-scale swings drives the blend into saturation
		'{ROW_CFG,    REG_DELAY,  18'd384,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh8000, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh8000, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b0, 16'sd0},
		// zero fraction: cubic collapses to the tap, two samples back
		'{ROW_CFG,    REG_DELAY,  18'd512,    16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sd1234, 1'b1, 16'sh7FFF},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      -16'sd1,   1'b0, 16'sd0},
		// largest register value: no clamp applies, a delay of 1023 samples plus 255/256
		'{ROW_CFG,    REG_DELAY,  18'h3FFFF,  16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      -16'sd7,   1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh7FFF, 1'b0, 16'sd0},
		// 1023-sample delay, plain tap: reads a slot not yet written
		'{ROW_CFG,    REG_DELAY,  18'd261888, 16'sd0,    1'b0, 16'sd0},
		'{ROW_CFG,    REG_INTERP, 18'd0,      16'sd0,    1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sd0,    1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_DELAY,  18'd0,      16'sh8000, 1'b0, 16'sd0}
	};

	// DUT ports; the inputs are known from time zero
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic signed [15:0]       sample_in = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [15:0]       sample_out;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data  = '0;

	// shadow of the delay line, kept in step with accepted input beats
	logic signed [15:0]       line_mem [LINE_LEN] = '{default: '0};
	int                       wr_pos    = LINE_LEN / 2;
	logic [DELAY_W-1:0]       delay_reg = DELAY_W'(DELAY_RESET);
	logic                     cubic_on  = 1'b0;

	logic signed [15:0]       delayed_q [$];   // predicted sample_out, oldest first
	int                       n_errors  = 0;
	bit                       burst     = 1'b0; // no idling on either side while set

	fractional_delay_line_cubic_top #(
		.BUF_LEN     (LINE_LEN),
		.SAMPLE_BITS (16)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Store the new sample, then tap delay/256 samples behind the write slot.
	// Cubic blend is done exactly in 2^24 scale; floor of (acc + half) rounds
	// to nearest with ties upward.
	function automatic logic signed [15:0] predict_delayed(input logic signed [15:0] smp);
		longint dly, pos, ym1, y0, y1, y2, ca, cb, cc, fr, acc, q;
		int     tap;
		line_mem[LINE_AW'(wr_pos)] = smp;
		dly = longint'(delay_reg);
		if (dly < DELAY_MIN) begin
			dly = longint'(DELAY_MIN);
		end else if (dly >= LINE_UNITS) begin
			dly = longint'(LINE_UNITS - FRAC_ONE);
		end
		pos = longint'(wr_pos) * FRAC_ONE + LINE_UNITS - dly;
		if (pos >= LINE_UNITS) begin
			pos -= LINE_UNITS;
		end
		tap = int'(pos >> FRAC_BITS);
		fr  = pos & longint'(FRAC_ONE - 1);
		if (cubic_on) begin
			ym1 = longint'(line_mem[LINE_AW'((tap + LINE_LEN - 1) % LINE_LEN)]);
			y0  = longint'(line_mem[LINE_AW'(tap)]);
			y1  = longint'(line_mem[LINE_AW'((tap + 1) % LINE_LEN)]);
			y2  = longint'(line_mem[LINE_AW'((tap + 2) % LINE_LEN)]);
			ca  = y0 - y1 + y2 - ym1;
			cb  = 2 * ym1 - 2 * y0 + y1 - y2;
			cc  = y1 - ym1;
			acc = fr * fr * fr * ca + 256 * fr * fr * cb + 65536 * fr * cc
				+ 64'sd16777216 * y0 + 64'sd8388608;
			q = acc >>> 24;
			if (q > 32767) begin
				q = 64'sd32767;
			end else if (q < -32768) begin
				q = -64'sd32768;
			end
		end else begin
			q = longint'(line_mem[LINE_AW'(tap)]);
		end
		wr_pos = (wr_pos + 1) % LINE_LEN;
		return 16'(q);
	endfunction

	// Register write: one cycle of write enable, then the enable drops before the shadow settings update.
	// Called at a rising edge.
	task automatic write_reg(input cfg_reg_t sel, input logic [DELAY_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (sel)
			REG_DELAY:  delay_reg = val;
			REG_INTERP: cubic_on  = val[0];
			default:    ;
		endcase
	endtask

	// One input beat. Valid stays up across back-to-back beats; it only drops
	// for a drawn gap or in drain_line. The expectation is logged on the accepting edge.
	task automatic send_sample(input logic signed [15:0] smp, input logic pinned,
			input logic signed [15:0] want);
		int                 gap;
		logic signed [15:0] pred;
		gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= smp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_delayed(smp);
		delayed_q.push_back(pinned ? want : pred);
	endtask

	// Block goes idle: input valid drops, every expected result collected.
	task automatic drain_line();
		in_valid <= 1'b0;
		while (delayed_q.size() != 0) @(posedge clk);
	endtask

	// Output side: random stall before each beat, then check against the oldest
	// expectation. Signals are read right at the edge, before the DUT updates.
	initial begin
		logic signed [15:0] want;
		int                 stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (delayed_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected sample_out beat: expected none, got %0d",
					$time, sample_out);
			end else begin
				want = delayed_q.pop_front();
				if (sample_out !== want) begin
					n_errors++;
					$display("%0t: sample_out mismatch: expected %0d, got %0d",
						$time, want, sample_out);
				end
			end
		end
	end

	// Stimulus: directed table, then random phases, each under its own settings.
	initial begin
		logic [DELAY_W-1:0] dly;
		logic               on;
		logic signed [15:0] smp;
		int                 n_items;
		stim_row_t          row;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			row = DIRECTED[ROW_AW'(r)];
			if (row.kind == ROW_CFG) begin
				drain_line();
				write_reg(row.reg_sel, row.cfg_val);
			end else begin
				send_sample(row.smp, row.pinned, row.want);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_line();
			// first phases pin the extremes of the delay range
			if (ph == 0) begin
				dly = DELAY_W'(DELAY_MIN);
			end else if (ph == 1) begin
				dly = 18'd261888;
			end else if (ph == 2) begin
				dly = '0;
			end else begin
				case ($urandom_range(0, 4))
					0:       dly = 18'($urandom_range(0, DELAY_MIN - 1));
					1:       dly = 18'($urandom_range(1, LINE_LEN - 1) * FRAC_ONE);
					2:       dly = 18'($urandom);
					3:       dly = 18'($urandom_range(DELAY_MIN, 6 * FRAC_ONE));
					default: dly = 18'h3FFFF;
				endcase
			end
			on = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
			write_reg(REG_DELAY, dly);
			// upper data bits are don't-care for the mode bit; toggle them anyway
			write_reg(REG_INTERP, (18'($urandom) & 18'h3FFFE) | 18'(on));
			burst   = (ph > 1) && ($urandom_range(0, 3) == 0);
			n_items = $urandom_range(100, 160);
			for (int i = 0; i < n_items; i++) begin
				case ($urandom_range(0, 9))
					0:       smp = 16'sh7FFF;
					1:       smp = 16'sh8000;
					2:       smp = 16'($urandom_range(0, 8) - 4);
					default: smp = 16'($urandom);
				endcase
				send_sample(smp, 1'b0, 16'sd0);
			end
		end

		burst = 1'b0;
		drain_line();
		repeat (END_SETTLE) @(posedge clk);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- fractional_delay_line_cubic_top.f -----
hdl/fdlc_pkg.sv
hdl/fdlc_cubic.sv
hdl/fractional_delay_line_cubic_top.sv
tb/testbench.sv
